// ===== hdl/glzw_pkg.sv =====
package glzw_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = 12;
    localparam int ACC_W       = 20;

    // Result status codes
    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_STARVED = 3'd1;
    localparam logic [2:0] ST_TAKEN   = 3'd2;
    localparam logic [2:0] ST_REFUSED = 3'd3;
    localparam logic [2:0] ST_ENDED   = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MIN_SIZE   = 1'b0;
    localparam logic CFG_LINE_WIDTH = 1'b1;

    typedef enum logic [1:0] {
        PH_AWAIT = 2'd0,
        PH_RUN   = 2'd1,
        PH_ENDED = 2'd2
    } phase_t;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_PULL = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PULL,
        S_POP_RD,
        S_CODE,
        S_WALK,
        S_WALK_RD,
        S_EMIT
    } back_state_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    // Clamp the minimum code size to its legal range
    function automatic logic [3:0] eff_size(input logic [3:0] min_size,
                                            input logic [3:0] max_bits);
        logic [3:0] m;
        m = min_size;
        if (m < 4'd2) m = 4'd2;
        if (m > 4'd9) m = 4'd9;
        if (m + 4'd1 > max_bits) m = max_bits - 4'd1;
        return m;
    endfunction

endpackage

// ===== hdl/glzw_ram.sv =====
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/glzw_front.sv =====
module glzw_front
    import glzw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] data_byte,
    output item_t      item,
    input  logic       item_pop
);

    logic [8:0] slot_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = item_pop && (count_reg != 2'd0);

    // Classify head entry
    assign item.valid = (count_reg != 2'd0);
    assign item.kind  = slot_reg[rd_ptr_reg][8] ? KIND_PULL : KIND_BYTE;
    assign item.data  = slot_reg[rd_ptr_reg][7:0];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= {action, data_byte};
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |=> (count_reg <= 2'd1)) else $error("queue underflow");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !push) else $error("push into full queue");

endmodule

// ===== hdl/glzw_back.sv =====
module glzw_back
    import glzw_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    output logic        item_pop,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel_index,
    output logic [2:0]  status,
    output logic        line_end,
    output logic        bad_code_seen
);

    localparam logic [3:0]  MAXB     = 4'(MAX_CODE_BITS);
    localparam logic [12:0] DEPTH13  = 13'(TABLE_DEPTH);

    back_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  min_size_reg, min_size_next;
    logic [15:0] line_width_reg, line_width_next;
    logic [12:0] stack_count_reg, stack_count_next;
    logic [12:0] next_slot_reg, next_slot_next;
    logic [3:0]  code_width_reg, code_width_next;
    logic [13:0] width_limit_reg, width_limit_next;
    logic [11:0] prev_code_reg, prev_code_next;
    logic [7:0]  first_char_reg, first_char_next;
    logic [ACC_W-1:0] accum_reg, accum_next;
    logic [4:0]  accum_bits_reg, accum_bits_next;
    logic [7:0]  block_left_reg, block_left_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic        closed_reg, closed_next;
    logic [15:0] pix_line_reg, pix_line_next;
    logic [15:0] bad_count_reg, bad_count_next;
    logic [11:0] cur_code_reg, cur_code_next;
    logic [11:0] walk_code_reg, walk_code_next;
    logic [7:0]  res_pix_reg, res_pix_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic        res_lend_reg, res_lend_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_pix_reg, out_pix_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic        out_lend_reg, out_lend_next;
    logic        out_bad_reg, out_bad_next;

    // Memory ports
    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr, stk_raddr;
    logic [7:0]        stk_wdata, stk_rdata;
    logic              tab_we;
    logic [ADDR_W-1:0] tab_raddr;
    logic [11:0]       pre_rdata;
    logic [7:0]        suf_rdata;

    logic [3:0]  m_eff;
    logic [12:0] clr_code, end_code, first_code;
    logic [11:0] width_mask;
    logic [11:0] new_code;
    logic        walk_more;
    logic        add_entry;
    logic [12:0] slot_after;
    logic [16:0] line_sum;
    logic        slot_free;

    assign m_eff      = eff_size(min_size_reg, MAXB);
    assign clr_code   = 13'd1 << m_eff;
    assign end_code   = clr_code + 13'd1;
    assign first_code = clr_code + 13'd2;
    assign width_mask = 12'((20'd1 << code_width_reg) - 20'd1);
    assign new_code   = accum_reg[11:0] & width_mask;
    assign walk_more  = ({1'b0, walk_code_reg} >= first_code)
                     && ({1'b0, walk_code_reg} < next_slot_reg)
                     && (stack_count_reg < DEPTH13 - 13'd1);
    assign add_entry  = (next_slot_reg < {1'b0, width_limit_reg[12:0]}
                         || width_limit_reg[13])
                     && (next_slot_reg < DEPTH13);
    assign slot_after = add_entry ? next_slot_reg + 13'd1 : next_slot_reg;
    assign line_sum   = {1'b0, pix_line_reg} + 17'd1;
    assign slot_free  = !out_valid_reg || !out_stall;

    glzw_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata));
    glzw_ram #(.WIDTH(12), .DEPTH(TABLE_DEPTH)) u_prefix (
        .clk(clk), .we(tab_we), .waddr(next_slot_reg[ADDR_W-1:0]),
        .wdata(prev_code_reg), .raddr(tab_raddr), .rdata(pre_rdata));
    glzw_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_suffix (
        .clk(clk), .we(tab_we), .waddr(next_slot_reg[ADDR_W-1:0]),
        .wdata(walk_code_reg[7:0]), .raddr(tab_raddr), .rdata(suf_rdata));

    // Memory controls by state
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = stack_count_reg[ADDR_W-1:0];
        stk_wdata = walk_code_reg[7:0];
        stk_raddr = 12'(stack_count_reg - 13'd1);
        tab_we    = 1'b0;
        tab_raddr = walk_code_reg;
        item_pop  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_pop = item.valid && !(cfg_we && cfg_index == CFG_MIN_SIZE);
            end
            S_CODE:
            begin
                if ({1'b0, cur_code_reg} != clr_code && {1'b0, cur_code_reg} != end_code)
                begin
                    if (phase_reg == PH_AWAIT)
                    begin
                        stk_we    = stack_count_reg < DEPTH13;
                        stk_wdata = ({1'b0, cur_code_reg} >= next_slot_reg)
                                    ? 8'd0 : cur_code_reg[7:0];
                    end
                    else if ({1'b0, cur_code_reg} >= next_slot_reg)
                    begin
                        stk_we    = stack_count_reg < DEPTH13;
                        stk_wdata = first_char_reg;
                    end
                end
            end
            S_WALK:
            begin
                if (!walk_more)
                begin
                    stk_we    = stack_count_reg < DEPTH13;
                    stk_wdata = walk_code_reg[7:0];
                    tab_we    = add_entry;
                end
            end
            S_WALK_RD:
            begin
                stk_we    = 1'b1;
                stk_wdata = suf_rdata;
            end
            default:
            begin
            end
        endcase
    end

    // Next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        min_size_next    = min_size_reg;
        line_width_next  = line_width_reg;
        stack_count_next = stack_count_reg;
        next_slot_next   = next_slot_reg;
        code_width_next  = code_width_reg;
        width_limit_next = width_limit_reg;
        prev_code_next   = prev_code_reg;
        first_char_next  = first_char_reg;
        accum_next       = accum_reg;
        accum_bits_next  = accum_bits_reg;
        block_left_next  = block_left_reg;
        held_byte_next   = held_byte_reg;
        held_valid_next  = held_valid_reg;
        closed_next      = closed_reg;
        pix_line_next    = pix_line_reg;
        bad_count_next   = bad_count_reg;
        cur_code_next    = cur_code_reg;
        walk_code_next   = walk_code_reg;
        res_pix_next     = res_pix_reg;
        res_status_next  = res_status_reg;
        res_lend_next    = res_lend_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_pix_next     = out_pix_reg;
        out_status_next  = out_status_reg;
        out_lend_next    = out_lend_reg;
        out_bad_next     = out_bad_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    res_pix_next  = 8'd0;
                    res_lend_next = 1'b0;
                    if (item.kind == KIND_PULL)
                    begin
                        state_next = S_PULL;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                        if (phase_reg == PH_ENDED || closed_reg || held_valid_reg)
                        begin
                            res_status_next = ST_REFUSED;
                        end
                        else if (block_left_reg == 8'd0)
                        begin
                            res_status_next = ST_TAKEN;
                            if (item.data == 8'd0) closed_next = 1'b1;
                            else block_left_next = item.data;
                        end
                        else
                        begin
                            res_status_next = ST_TAKEN;
                            held_byte_next  = item.data;
                            held_valid_next = 1'b1;
                            block_left_next = block_left_reg - 8'd1;
                        end
                    end
                end
            end
            S_PULL:
            begin
                if (stack_count_reg != 13'd0)
                begin
                    stack_count_next = stack_count_reg - 13'd1;
                    state_next       = S_POP_RD;
                end
                else if (phase_reg == PH_ENDED)
                begin
                    res_status_next = ST_ENDED;
                    state_next      = S_EMIT;
                end
                else if ({1'b0, accum_bits_reg} < {2'b0, code_width_reg})
                begin
                    if (held_valid_reg)
                    begin
                        accum_next      = accum_reg
                                        | (ACC_W'(held_byte_reg) << accum_bits_reg);
                        accum_bits_next = accum_bits_reg + 5'd8;
                        held_valid_next = 1'b0;
                    end
                    else if (closed_reg)
                    begin
                        phase_next      = PH_ENDED;
                        res_status_next = ST_ENDED;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        res_status_next = ST_STARVED;
                        state_next      = S_EMIT;
                    end
                end
                else
                begin
                    cur_code_next   = new_code;
                    accum_next      = accum_reg >> code_width_reg;
                    accum_bits_next = accum_bits_reg - {1'b0, code_width_reg};
                    state_next      = S_CODE;
                end
            end
            S_POP_RD:
            begin
                res_pix_next    = stk_rdata;
                res_status_next = ST_PIXEL;
                if (line_sum >= {1'b0, line_width_reg})
                begin
                    res_lend_next = 1'b1;
                    pix_line_next = 16'd0;
                end
                else
                begin
                    pix_line_next = line_sum[15:0];
                end
                state_next = S_EMIT;
            end
            S_CODE:
            begin
                state_next = S_PULL;
                if ({1'b0, cur_code_reg} == clr_code)
                begin
                    code_width_next  = m_eff + 4'd1;
                    width_limit_next = 14'd1 << (m_eff + 4'd1);
                    next_slot_next   = clr_code + 13'd2;
                    phase_next       = PH_AWAIT;
                end
                else if ({1'b0, cur_code_reg} == end_code)
                begin
                    phase_next = PH_ENDED;
                end
                else if (phase_reg == PH_AWAIT)
                begin
                    if ({1'b0, cur_code_reg} >= next_slot_reg)
                    begin
                        prev_code_next  = 12'd0;
                        first_char_next = 8'd0;
                    end
                    else
                    begin
                        prev_code_next  = cur_code_reg;
                        first_char_next = cur_code_reg[7:0];
                    end
                    if (stack_count_reg < DEPTH13) stack_count_next = stack_count_reg + 13'd1;
                    phase_next = PH_RUN;
                end
                else
                begin
                    state_next = S_WALK;
                    if ({1'b0, cur_code_reg} >= next_slot_reg)
                    begin
                        if ({1'b0, cur_code_reg} > next_slot_reg && bad_count_reg != 16'hFFFF)
                        begin
                            bad_count_next = bad_count_reg + 16'd1;
                        end
                        walk_code_next = prev_code_reg;
                        if (stack_count_reg < DEPTH13) stack_count_next = stack_count_reg + 13'd1;
                    end
                    else
                    begin
                        walk_code_next = cur_code_reg;
                    end
                end
            end
            S_WALK:
            begin
                if (walk_more)
                begin
                    state_next = S_WALK_RD;
                end
                else
                begin
                    if (stack_count_reg < DEPTH13) stack_count_next = stack_count_reg + 13'd1;
                    if (add_entry)
                    begin
                        first_char_next = walk_code_reg[7:0];
                        next_slot_next  = slot_after;
                        prev_code_next  = cur_code_reg;
                    end
                    if ({1'b0, slot_after} >= width_limit_reg && code_width_reg < MAXB)
                    begin
                        width_limit_next = width_limit_reg << 1;
                        code_width_next  = code_width_reg + 4'd1;
                    end
                    state_next = S_PULL;
                end
            end
            S_WALK_RD:
            begin
                stack_count_next = stack_count_reg + 13'd1;
                walk_code_next   = pre_rdata;
                state_next       = S_WALK;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pix_next    = res_pix_reg;
                    out_status_next = res_status_reg;
                    out_lend_next   = res_lend_reg;
                    out_bad_next    = (bad_count_reg != 16'd0);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes must arrive only while idle; the block does not enforce this
        if (cfg_we)
        begin
            if (cfg_index == CFG_LINE_WIDTH)
            begin
                line_width_next = cfg_data;
            end
            else
            begin
                min_size_next    = cfg_data[3:0];
                state_next       = S_IDLE;
                phase_next       = PH_AWAIT;
                stack_count_next = 13'd0;
                prev_code_next   = 12'd0;
                first_char_next  = 8'd0;
                accum_next       = '0;
                accum_bits_next  = 5'd0;
                block_left_next  = 8'd0;
                held_byte_next   = 8'd0;
                held_valid_next  = 1'b0;
                closed_next      = 1'b0;
                pix_line_next    = 16'd0;
                bad_count_next   = 16'd0;
                code_width_next  = eff_size(cfg_data[3:0], MAXB) + 4'd1;
                width_limit_next = 14'd1 << (eff_size(cfg_data[3:0], MAXB) + 4'd1);
                next_slot_next   = (13'd1 << eff_size(cfg_data[3:0], MAXB)) + 13'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_AWAIT;
            min_size_reg    <= 4'd8;
            line_width_reg  <= 16'd320;
            stack_count_reg <= 13'd0;
            next_slot_reg   <= (13'd1 << eff_size(4'd8, MAXB)) + 13'd2;
            code_width_reg  <= eff_size(4'd8, MAXB) + 4'd1;
            width_limit_reg <= 14'd1 << (eff_size(4'd8, MAXB) + 4'd1);
            prev_code_reg   <= 12'd0;
            first_char_reg  <= 8'd0;
            accum_reg       <= '0;
            accum_bits_reg  <= 5'd0;
            block_left_reg  <= 8'd0;
            held_byte_reg   <= 8'd0;
            held_valid_reg  <= 1'b0;
            closed_reg      <= 1'b0;
            pix_line_reg    <= 16'd0;
            bad_count_reg   <= 16'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            min_size_reg    <= min_size_next;
            line_width_reg  <= line_width_next;
            stack_count_reg <= stack_count_next;
            next_slot_reg   <= next_slot_next;
            code_width_reg  <= code_width_next;
            width_limit_reg <= width_limit_next;
            prev_code_reg   <= prev_code_next;
            first_char_reg  <= first_char_next;
            accum_reg       <= accum_next;
            accum_bits_reg  <= accum_bits_next;
            block_left_reg  <= block_left_next;
            held_byte_reg   <= held_byte_next;
            held_valid_reg  <= held_valid_next;
            closed_reg      <= closed_next;
            pix_line_reg    <= pix_line_next;
            bad_count_reg   <= bad_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_code_reg   <= cur_code_next;
        walk_code_reg  <= walk_code_next;
        res_pix_reg    <= res_pix_next;
        res_status_reg <= res_status_next;
        res_lend_reg   <= res_lend_next;
        out_pix_reg    <= out_pix_next;
        out_status_reg <= out_status_next;
        out_lend_reg   <= out_lend_next;
        out_bad_reg    <= out_bad_next;
    end

    assign out_valid     = out_valid_reg;
    assign pixel_index   = out_pix_reg;
    assign status        = out_status_reg;
    assign line_end      = out_lend_reg;
    assign bad_code_seen = out_bad_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count_reg <= DEPTH13) else $error("stack count overflow");
    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        code_width_reg >= 4'd3 && code_width_reg <= MAXB) else $error("code width range");
    a_accum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accum_bits_reg <= 5'd19) else $error("accumulator overflow");
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_slot_reg <= DEPTH13) else $error("next slot beyond table");

endmodule

// ===== hdl/gif_lzw_pixel_decoder_unit.sv =====
// GIF LZW pixel decoder.
// Input channel (in_valid/in_stall, action, data_byte): action 0 offers one
// byte of the raw image data stream, block-length bytes included; action 1
// pulls the next pixel. Every input transfer yields exactly one result on the
// output channel (out_valid/out_stall): pixel_index, status (pixel, needs
// bytes, byte taken, byte refused, image ended), line_end and bad_code_seen.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 writes min_code_size and
// starts a new image, index 1 writes line_width.
// A byte offer goes from idle straight to the result stage. A pull pops the
// string stack if it holds pixels; on an empty stack it merges any held
// byte into the bit accumulator, reports a starved or ended result when no
// bits are left to take, and otherwise fetches a code and walks its prefix
// chain through the registered-read prefix/suffix RAMs.
// Items are handled one at a time; the next one starts after the result is
// loaded. A two-entry input queue keeps accepting while a result waits in the
// output register; when out_stall holds, results and then the queue back up.
// Reset clears all control state; table contents are left undefined and are
// only read after being written.
module gif_lzw_pixel_decoder_unit
    import glzw_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pixel_index,
    output logic [2:0]  status,
    output logic        line_end,
    output logic        bad_code_seen,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    item_t item;
    logic  item_pop;

    glzw_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .data_byte(data_byte), .item(item), .item_pop(item_pop));

    glzw_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .item(item), .item_pop(item_pop),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_index(pixel_index),
        .status(status), .line_end(line_end), .bad_code_seen(bad_code_seen));

endmodule
